@@ src/bf3_pkg.sv @@
// ----------------------------------------------------------------------------
// bf3_pkg
// Types and constants shared by the 3x3 box filter modules.
// ----------------------------------------------------------------------------
package bf3_pkg;

	localparam int PIX_W     = 16;
	localparam int POS_W     = 10;
	localparam int CFG_W     = 11;
	localparam int CSUM_W    = 18;
	localparam int SUM_W     = 20;
	localparam int RECIP_W   = 23;
	localparam int RECIP_SH  = 24;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam int SIZE_RST  = 512;

	localparam logic [RECIP_W-1:0] RECIP_4 = 23'd4194304;
	localparam logic [RECIP_W-1:0] RECIP_6 = 23'd2796203;
	localparam logic [RECIP_W-1:0] RECIP_9 = 23'd1864136;

	typedef logic [2:0][PIX_W-1:0] rgb_t;

	typedef enum logic [1:0] {
		DIV_4,
		DIV_6,
		DIV_9
	} div_t;

	typedef struct packed {
		logic [PIX_W-1:0] in_red;
		logic [PIX_W-1:0] in_green;
		logic [PIX_W-1:0] in_blue;
	} pix_in_t;

	typedef struct packed {
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
		logic [PIX_W-1:0] out_red;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_blue;
		logic             run_last;
	} pix_out_t;

	typedef struct packed {
		logic [POS_W-1:0]          row;
		logic [POS_W-1:0]          col;
		logic [2:0][SUM_W-1:0]     sum;
		div_t                      div;
		logic                      last;
	} mean_req_t;

	function automatic logic [RECIP_W-1:0] recip(input div_t d);
		logic [RECIP_W-1:0] m;
		unique case (d)
			DIV_4:   m = RECIP_4;
			DIV_6:   m = RECIP_6;
			DIV_9:   m = RECIP_9;
			default: m = RECIP_4;
		endcase
		return m;
	endfunction

endpackage

@@ src/box_filter_3x3_rgb_unit.sv @@
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb_unit
// Streaming 3x3 mean filter over a square RGB image in raster order.
// A pixel's results pass stage 1, stage 2, the item queue and the divider's
// product and output registers. Throughput: one pixel per cycle while each
// pixel gives at most one result and results are not stalled; row-end and
// last-row pixels give 2 or 4 results, and the four-item result queue sets
// how long input keeps flowing meanwhile. Reset clears counters and
// handshake state and sets the size to 512, capped by MAX_SIZE; the line
// buffer memory is not cleared; entries read unwritten feed no result.
// ----------------------------------------------------------------------------
module box_filter_3x3_rgb_unit import bf3_pkg::*; #(
	parameter int MAX_SIZE = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_image_size,
	input  logic             pix_valid,
	output logic             pix_ready,
	input  pix_in_t          pix,
	output logic             res_valid,
	input  logic             res_ready,
	output pix_out_t         res
);

	localparam int ADDR_W     = $clog2(MAX_SIZE);
	localparam int SIZE_CAP   = (MAX_SIZE < 1024) ? MAX_SIZE : 1024;
	localparam int SIZE_INIT  = (SIZE_RST < SIZE_CAP) ? SIZE_RST : SIZE_CAP;
	localparam int ITEM_DEPTH = 4;
	localparam int PTR_W      = $clog2(ITEM_DEPTH);
	localparam int CNT_W      = $clog2(ITEM_DEPTH) + 1;

	typedef struct packed {
		rgb_t upper;
		rgb_t middle;
	} line_t;

	typedef struct packed {
		logic [POS_W-1:0]           row;
		logic [POS_W-1:0]           col;
		logic [3:0]                 mask;
		logic                       r3;
		logic                       c3;
		logic [3:0][2:0][SUM_W-1:0] sum;
	} item_t;

	// size and position
	logic [POS_W-1:0] last_idx_q;
	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] col_q;
	logic [CFG_W-1:0] n_cfg;
	logic             acc;
	logic             cfg_wr;
	logic             last_c;
	logic             last_r;
	logic [3:0]       mask0;

	// stage 1
	line_t            line_mem [MAX_SIZE];
	line_t            line_rd_s1;
	line_t            fwd_data_s1;
	logic             fwd_s1;
	line_t            line_s1;
	line_t            wr_data;
	logic             v_s1;
	rgb_t             px_s1;
	logic [POS_W-1:0] row_s1;
	logic [POS_W-1:0] col_s1;
	logic [3:0]       mask_s1;
	logic             r3_s1;
	logic             c3_s1;
	logic [2:0][CSUM_W-1:0] new_a;
	logic [2:0][CSUM_W-1:0] new_b;

	// column sums of the window, index 0 is the oldest column
	logic [2:0][2:0][CSUM_W-1:0] col_a_q;
	logic [2:0][2:0][CSUM_W-1:0] col_b_q;

	// stage 2
	logic             v_s2;
	logic [POS_W-1:0] row_s2;
	logic [POS_W-1:0] col_s2;
	logic [3:0]       mask_s2;
	logic             r3_s2;
	logic             c3_s2;
	item_t            item_s2;
	logic             push;

	// item queue and sequencer
	item_t            item_q [ITEM_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] busy;
	item_t            head;
	logic [3:0]       done_q;
	logic [3:0]       rem;
	logic [3:0]       sel;
	logic             seq_last;
	logic             pop;
	logic             req_valid;
	logic             req_ready;
	mean_req_t        req;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		priority if (cfg_image_size < CFG_W'(2)) begin
			n_cfg = CFG_W'(2);
		end else if (cfg_image_size > CFG_W'(SIZE_CAP)) begin
			n_cfg = CFG_W'(SIZE_CAP);
		end else begin
			n_cfg = cfg_image_size;
		end
	end

	assign busy      = cnt_q + CNT_W'(v_s1) + CNT_W'(v_s2);
	assign pix_ready = busy < CNT_W'(ITEM_DEPTH);
	assign acc       = pix_valid && pix_ready;

	assign last_c = (col_q == last_idx_q);
	assign last_r = (row_q == last_idx_q);
	assign mask0  = {last_r && last_c,
	                 last_r && (col_q != '0),
	                 (row_q != '0) && last_c,
	                 (row_q != '0) && (col_q != '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_idx_q <= POS_W'(SIZE_INIT - 1);
			row_q      <= '0;
			col_q      <= '0;
		end else begin
			priority if (cfg_wr) begin
				last_idx_q <= POS_W'(n_cfg - CFG_W'(1));
				row_q      <= '0;
				col_q      <= '0;
			end else if (acc) begin
				if (last_c) begin
					col_q <= '0;
					row_q <= last_r ? '0 : row_q + POS_W'(1);
				end else begin
					col_q <= col_q + POS_W'(1);
				end
			end
		end
	end

	// line buffer: read at accept, written back in the following cycle
	assign line_s1        = fwd_s1 ? fwd_data_s1 : line_rd_s1;
	assign wr_data.upper  = line_s1.middle;
	assign wr_data.middle = px_s1;

	always_ff @(posedge clk) begin
		if (v_s1) line_mem[ADDR_W'(col_s1)] <= wr_data;
		if (acc)  line_rd_s1 <= line_mem[ADDR_W'(col_q)];
	end

	always_ff @(posedge clk) begin
		fwd_data_s1 <= wr_data;
		if (acc) begin
			px_s1   <= {pix.in_blue, pix.in_green, pix.in_red};
			row_s1  <= row_q;
			col_s1  <= col_q;
			mask_s1 <= mask0;
			r3_s1   <= row_q >= POS_W'(2);
			c3_s1   <= col_q >= POS_W'(2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			v_s1   <= acc;
			fwd_s1 <= acc && v_s1 && (col_q == col_s1);
			v_s2   <= v_s1;
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			new_b[ch] = CSUM_W'(line_s1.middle[ch]) + CSUM_W'(px_s1[ch]);
			new_a[ch] = new_b[ch] + (r3_s1 ? CSUM_W'(line_s1.upper[ch]) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			col_a_q[0] <= col_a_q[1];
			col_a_q[1] <= col_a_q[2];
			col_a_q[2] <= new_a;
			col_b_q[0] <= col_b_q[1];
			col_b_q[1] <= col_b_q[2];
			col_b_q[2] <= new_b;
			row_s2     <= row_s1;
			col_s2     <= col_s1;
			mask_s2    <= mask_s1;
			r3_s2      <= r3_s1;
			c3_s2      <= c3_s1;
		end
	end

	// neighbour sums for the four possible results
	always_comb begin
		item_s2.row  = row_s2;
		item_s2.col  = col_s2;
		item_s2.mask = mask_s2;
		item_s2.r3   = r3_s2;
		item_s2.c3   = c3_s2;
		for (int ch = 0; ch < 3; ch++) begin
			item_s2.sum[1][ch] = SUM_W'(col_a_q[1][ch]) + SUM_W'(col_a_q[2][ch]);
			item_s2.sum[0][ch] = item_s2.sum[1][ch] + (c3_s2 ? SUM_W'(col_a_q[0][ch]) : '0);
			item_s2.sum[3][ch] = SUM_W'(col_b_q[1][ch]) + SUM_W'(col_b_q[2][ch]);
			item_s2.sum[2][ch] = item_s2.sum[3][ch] + (c3_s2 ? SUM_W'(col_b_q[0][ch]) : '0);
		end
	end

	assign push = v_s2 && (mask_s2 != '0);

	// result sequencer over the queue head
	assign head      = item_q[rd_ptr_q];
	assign rem       = head.mask & ~done_q;
	assign sel       = rem & (~rem + 4'd1);
	assign seq_last  = (rem & (rem - 4'd1)) == 4'd0;
	assign req_valid = cnt_q != '0;
	assign pop       = req_valid && req_ready && seq_last;

	always_comb begin
		req.last = seq_last;
		req.row  = head.row;
		req.col  = head.col;
		req.sum  = head.sum[3];
		req.div  = DIV_4;
		priority if (sel[0]) begin
			req.row = head.row - POS_W'(1);
			req.col = head.col - POS_W'(1);
			req.sum = head.sum[0];
			req.div = (head.r3 && head.c3) ? DIV_9 :
			          (head.r3 || head.c3) ? DIV_6 : DIV_4;
		end else if (sel[1]) begin
			req.row = head.row - POS_W'(1);
			req.sum = head.sum[1];
			req.div = head.r3 ? DIV_6 : DIV_4;
		end else if (sel[2]) begin
			req.col = head.col - POS_W'(1);
			req.sum = head.sum[2];
			req.div = head.c3 ? DIV_6 : DIV_4;
		end else begin
			req.sum = head.sum[3];
		end
	end

	always_ff @(posedge clk) begin
		if (push) item_q[wr_ptr_q] <= item_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			done_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
			if (req_valid && req_ready) begin
				done_q <= seq_last ? '0 : (done_q | sel);
			end
		end
	end

	bf3_mean_div u_mean_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// queue never takes an item it has no room for
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < CNT_W'(ITEM_DEPTH)) || pop)
		else $error("result queue overflow");

	// a result beat leaves only from a head with work left
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |-> (rem != '0) && $onehot(sel))
		else $error("sequencer issued from an empty head");

	// position stays inside the image
	assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= last_idx_q) && (col_q <= last_idx_q))
		else $error("pixel position out of range");

endmodule

@@ src/bf3_mean_div.sv @@
// ----------------------------------------------------------------------------
// bf3_mean_div
// Divides neighbour sums by 4, 6 or 9 through a reciprocal multiply and
// holds the finished result in an output register.
// ----------------------------------------------------------------------------
module bf3_mean_div import bf3_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  mean_req_t req,
	output logic      res_valid,
	input  logic      res_ready,
	output pix_out_t  res
);

	logic                   v_s1;
	logic                   v_o_q;
	logic                   o_adv;
	logic [2:0][PROD_W-1:0] prod_s1;
	logic [POS_W-1:0]       row_s1;
	logic [POS_W-1:0]       col_s1;
	logic                   last_s1;
	pix_out_t               res_q;

	assign o_adv     = !v_o_q || res_ready;
	assign req_ready = !v_s1 || o_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_o_q <= 1'b0;
		end else begin
			if (req_ready) v_s1  <= req_valid;
			if (o_adv)     v_o_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			for (int ch = 0; ch < 3; ch++) begin
				prod_s1[ch] <= PROD_W'(req.sum[ch]) * PROD_W'(recip(req.div));
			end
			row_s1  <= req.row;
			col_s1  <= req.col;
			last_s1 <= req.last;
		end
		if (v_s1 && o_adv) begin
			res_q.out_row   <= row_s1;
			res_q.out_col   <= col_s1;
			res_q.out_red   <= prod_s1[0][RECIP_SH +: PIX_W];
			res_q.out_green <= prod_s1[1][RECIP_SH +: PIX_W];
			res_q.out_blue  <= prod_s1[2][RECIP_SH +: PIX_W];
			res_q.run_last  <= last_s1;
		end
	end

	assign res_valid = v_o_q;
	assign res       = res_q;

endmodule

@@ test/tb_box_filter_3x3_rgb_unit.sv @@
// ----------------------------------------------------------------------------
// tb_box_filter_3x3_rgb_unit
// Self-checking testbench for the streaming 3x3 RGB mean filter. Pixels are
// sent in raster order with random gaps and the result port is stalled at
// random. A local model of the line buffers, window and counters predicts
// every smoothed pixel, and each result beat is checked field by field
// against the oldest prediction. Image sizes cover the reset size, the clamped
// low end, small images and the clamped high end.
// ----------------------------------------------------------------------------
module tb_box_filter_3x3_rgb_unit import bf3_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_DEPTH  = 1024;
	localparam int SETTLE_CYC  = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RAND_ITEMS  = 72;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_image_size;
	logic             pix_valid;
	logic             pix_ready;
	pix_in_t          pix;
	logic             res_valid;
	logic             res_ready;
	pix_out_t         res;

	box_filter_3x3_rgb_unit #(
		.MAX_SIZE(LINE_DEPTH)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_image_size(cfg_image_size),
		.pix_valid     (pix_valid),
		.pix_ready     (pix_ready),
		.pix           (pix),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res)
	);

	// filter model state
	rgb_t             line_up  [LINE_DEPTH];
	rgb_t             line_mid [LINE_DEPTH];
	rgb_t             win      [3][3];
	logic [CFG_W-1:0] img_size;
	int               cur_row;
	int               cur_col;

	pix_out_t pending_means [$];
	int       fail_count;
	int       cycle_count;
	bit       gaps_on;
	bit       stalls_on;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic pix_out_t mean_at(input int orow, input int ocol,
			input int r, input int c, input int n);
		pix_out_t o;
		int       rlo, rhi, clo, chi, wr, wc, cnt, ch;
		int       sum [3];
		int       m   [3];
		rlo = (orow - 1 < 0) ? 0 : orow - 1;
		rhi = (orow + 1 > n - 1) ? n - 1 : orow + 1;
		clo = (ocol - 1 < 0) ? 0 : ocol - 1;
		chi = (ocol + 1 > n - 1) ? n - 1 : ocol + 1;
		cnt = 0;
		for (ch = 0; ch < 3; ch++)
			sum[ch] = 0;
		for (int ir = rlo; ir <= rhi; ir++) begin
			for (int ic = clo; ic <= chi; ic++) begin
				wr = ir - (r - 2);
				wc = ic - (c - 2);
				if (wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2) begin
					for (ch = 0; ch < 3; ch++)
						sum[ch] += int'(win[wr][wc][ch]);
					cnt++;
				end
			end
		end
		for (ch = 0; ch < 3; ch++) begin
			if (cnt == 4)
				m[ch] = sum[ch] >> 2;
			else if (cnt == 6)
				m[ch] = sum[ch] / 6;
			else if (cnt == 9)
				m[ch] = sum[ch] / 9;
			else
				m[ch] = 0;
		end
		o.out_row   = POS_W'(orow);
		o.out_col   = POS_W'(ocol);
		o.out_red   = PIX_W'(m[0]);
		o.out_green = PIX_W'(m[1]);
		o.out_blue  = PIX_W'(m[2]);
		o.run_last  = 1'b0;
		return o;
	endfunction

	task automatic smooth_pixel(input pix_in_t p);
		pix_out_t outs [$];
		rgb_t     px;
		int       n, r, c;
		n = (img_size < 2) ? 2 : ((img_size > LINE_DEPTH) ? LINE_DEPTH : int'(img_size));
		if (cur_row >= n || cur_col >= n) begin
			cur_row = 0;
			cur_col = 0;
		end
		r = cur_row;
		c = cur_col;
		px[0] = p.in_red;
		px[1] = p.in_green;
		px[2] = p.in_blue;
		for (int wr = 0; wr < 3; wr++) begin
			win[wr][0] = win[wr][1];
			win[wr][1] = win[wr][2];
		end
		win[0][2]   = line_up[c];
		win[1][2]   = line_mid[c];
		win[2][2]   = px;
		line_up[c]  = line_mid[c];
		line_mid[c] = px;
		if (r >= 1 && c >= 1)
			outs.push_back(mean_at(r - 1, c - 1, r, c, n));
		if (r >= 1 && c == n - 1)
			outs.push_back(mean_at(r - 1, c, r, c, n));
		if (r == n - 1 && c >= 1)
			outs.push_back(mean_at(r, c - 1, r, c, n));
		if (r == n - 1 && c == n - 1)
			outs.push_back(mean_at(r, c, r, c, n));
		if (outs.size() > 0)
			outs[outs.size() - 1].run_last = 1'b1;
		foreach (outs[i])
			pending_means.push_back(outs[i]);
		if (c == n - 1) begin
			cur_col = 0;
			cur_row = (r == n - 1) ? 0 : cur_row + 1;
		end else begin
			cur_col = cur_col + 1;
		end
	endtask

	// result beat checker
	always @(posedge clk) begin
		pix_out_t e;
		if (arst_n && res_valid && res_ready) begin
			if (pending_means.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected beat %0d,%0d %h %h %h %b",
						res.out_row, res.out_col, res.out_red, res.out_green,
						res.out_blue, res.run_last);
				fail_count++;
			end else begin
				e = pending_means.pop_front();
				if (res.out_row !== e.out_row || res.out_col !== e.out_col ||
						res.out_red !== e.out_red || res.out_green !== e.out_green ||
						res.out_blue !== e.out_blue || res.run_last !== e.run_last) begin
					if (fail_count < 10)
						$display("mismatch exp %0d,%0d %h %h %h %b got %0d,%0d %h %h %h %b",
							e.out_row, e.out_col, e.out_red, e.out_green, e.out_blue,
							e.run_last, res.out_row, res.out_col, res.out_red,
							res.out_green, res.out_blue, res.run_last);
					fail_count++;
				end
			end
		end
	end

	// result side back-pressure
	initial begin
		int w;
		res_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			w = stalls_on ? $urandom_range(0, 3) : 0;
			repeat (w) begin
				res_ready <= 1'b0;
				@(negedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!(res_valid && res_ready));
			@(negedge clk);
		end
	end

	function automatic pix_in_t rand_pixel();
		pix_in_t p;
		p.in_red   = PIX_W'($urandom);
		p.in_green = PIX_W'($urandom);
		p.in_blue  = PIX_W'($urandom);
		return p;
	endfunction

	task automatic send_pixel(input pix_in_t p);
		int gap;
		gap = gaps_on ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= p;
		do @(posedge clk); while (!(pix_valid && pix_ready));
		smooth_pixel(p);
		@(negedge clk);
	endtask

	task automatic settle();
		pix_valid <= 1'b0;
		while (pending_means.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_size(input int v);
		settle();
		cfg_valid      <= 1'b1;
		cfg_image_size <= CFG_W'(v);
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		img_size = CFG_W'(v);
		cur_row  = 0;
		cur_col  = 0;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_size();
		repeat (6) send_pixel(rand_pixel());
	endtask

	task automatic test_smallest_image();
		write_size(2);
		send_pixel({16'h0000, 16'hFFFF, 16'hAAAA});
		send_pixel({16'hFFFF, 16'h0000, 16'h5555});
		send_pixel({16'h0000, 16'hFFFF, 16'h5555});
		send_pixel({16'hFFFF, 16'h0000, 16'hAAAA});
		repeat (4) send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF});
	endtask

	task automatic test_size_clamp_low();
		write_size(0);
		repeat (4) send_pixel(rand_pixel());
		write_size(1);
		repeat (4) send_pixel(rand_pixel());
	endtask

	task automatic test_three_by_three();
		logic [PIX_W-1:0] blues [9];
		blues = '{16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001,
			16'hFFFF, 16'hFFFF, 16'hFFFF};
		write_size(3);
		foreach (blues[i])
			send_pixel({16'hFFFF, 16'h0000, blues[i]});
	endtask

	task automatic test_random_images();
		int sent, n, cnt, kind;
		sent = 0;
		while (sent < RAND_ITEMS) begin
			kind      = $urandom_range(0, 9);
			gaps_on   = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			if (kind == 0) begin
				n   = $urandom_range(0, 2047);
				cnt = $urandom_range(1, 12);
			end else begin
				n   = (kind < 8) ? $urandom_range(2, 5) : $urandom_range(6, 8);
				cnt = ($urandom_range(0, 3) == 0) ? 2 * n * n : n * n;
				if ($urandom_range(0, 3) == 0)
					cnt = $urandom_range(1, n * n - 1);
			end
			if (cnt > RAND_ITEMS - sent)
				cnt = RAND_ITEMS - sent;
			write_size(n);
			repeat (cnt) send_pixel(rand_pixel());
			sent += cnt;
		end
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
	endtask

	task automatic test_size_clamp_high();
		write_size(2047);
		repeat (4) send_pixel(rand_pixel());
		write_size(LINE_DEPTH);
		repeat (4) send_pixel(rand_pixel());
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_image_size = '0;
		pix_valid      = 1'b0;
		pix            = '0;
		fail_count     = 0;
		cycle_count    = 0;
		gaps_on        = 1'b1;
		stalls_on      = 1'b1;
		img_size       = CFG_W'(SIZE_RST);
		cur_row        = 0;
		cur_col        = 0;
		foreach (line_up[i]) begin
			line_up[i]  = '0;
			line_mid[i] = '0;
		end
		foreach (win[i, j])
			win[i][j] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_size();
		test_smallest_image();
		test_size_clamp_low();
		test_three_by_three();
		test_random_images();
		test_size_clamp_high();
		settle();
		if (fail_count == 0 && pending_means.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/bf3_pkg.sv
src/bf3_mean_div.sv
src/box_filter_3x3_rgb_unit.sv
test/tb_box_filter_3x3_rgb_unit.sv
